>>> rtl/itg_pkg.sv
// ---------------------------------------------------------------------------
// itg_pkg: shared types and constants for the tile grid generator
// Split strategy codes, field widths and the divider result bundle.
// ---------------------------------------------------------------------------
`default_nettype none

package itg_pkg;

  // field widths
  localparam int COORD_W = 16;
  localparam int CNT_W   = 7;
  localparam int ID_W    = 6;
  localparam int ROOT_W  = 4;
  localparam int SQ_W    = 8;
  localparam int STEP_W  = 4;

  // split strategy codes
  typedef enum logic [1:0] {
    STRAT_VERT   = 2'd0,
    STRAT_HORZ   = 2'd1,
    STRAT_RECT   = 2'd2,
    STRAT_SINGLE = 2'd3
  } strategy_t;

  // quotient and remainder from the shared divider
  typedef struct packed {
    logic [COORD_W-1:0] quot;
    logic [CNT_W-1:0]   rem;
  } div_res_t;

  // smallest power of two not below v (v is at most 11 here)
  function automatic logic [CNT_W-1:0] pow2_ceil(input logic [ROOT_W-1:0] v);
    logic [ROOT_W:0] p;
    p = (ROOT_W+1)'(1);
    for (int i = 0; i < ROOT_W; i++) begin
      if (p < {1'b0, v}) begin
        p = {p[ROOT_W-1:0], 1'b0};
      end
    end
    return {{(CNT_W-ROOT_W-1){1'b0}}, p};
  endfunction

endpackage

`default_nettype wire

>>> rtl/itg_div.sv
// ---------------------------------------------------------------------------
// itg_div: shared restoring divider
// Divides a 16-bit value by a 7-bit nonzero divisor, one quotient bit a cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module itg_div
  import itg_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               go,
  input  wire logic [COORD_W-1:0] dividend,
  input  wire logic [CNT_W-1:0]   divisor,
  output logic                    done,
  output div_res_t                res
);

  logic               running;
  logic [STEP_W-1:0]  step;
  logic [COORD_W-1:0] shreg;
  logic [CNT_W-1:0]   rem;
  logic [CNT_W-1:0]   dsr;

  logic [CNT_W:0]     trial;
  logic [CNT_W:0]     diff;
  logic               fits;
  logic [CNT_W-1:0]   rem_next;

  // one trial subtraction per cycle
  always_comb begin
    trial    = {rem, shreg[COORD_W-1]};
    diff     = trial - {1'b0, dsr};
    fits     = (trial >= {1'b0, dsr});
    rem_next = fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      step    <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        running <= 1'b1;
        step    <= '0;
      end else if (running) begin
        step <= step + STEP_W'(1);
        if (step == STEP_W'(COORD_W - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (go) begin
      shreg <= dividend;
      rem   <= '0;
      dsr   <= divisor;
    end else if (running) begin
      shreg <= {shreg[COORD_W-2:0], fits};
      rem   <= rem_next;
    end
  end

  assign res.quot = shreg;
  assign res.rem  = rem;

endmodule

`default_nettype wire

>>> rtl/image_tile_grid_generator_core.sv
// ---------------------------------------------------------------------------
// image_tile_grid_generator_core: tile grid generator
// Splits an image into a row-major grid of tiles and emits one tile a cycle.
// ---------------------------------------------------------------------------
// setup: rectangles first step an integer square root; then up to three
// passes of the shared divider (rows, column step, row step) run before the
// first tile appears, then one tile per cycle.
// a request occupies the block (busy high) until its last tile; the divider
// sets the setup time. results cannot be stalled.
// reset: rst (synchronous) returns the sequencer to idle with no tile pending.
`default_nettype none

module image_tile_grid_generator_core
  import itg_pkg::*;
#(
  parameter int MAX_TILES = 64
)(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         strategy,
  input  wire logic [CNT_W-1:0]   tile_count,
  input  wire logic [COORD_W-1:0] frame_width,
  input  wire logic [COORD_W-1:0] frame_height,
  output logic                    tile_valid,
  output logic [ID_W-1:0]         tile_id,
  output logic [COORD_W-1:0]      origin_x,
  output logic [COORD_W-1:0]      origin_y,
  output logic [COORD_W-1:0]      extent_x,
  output logic [COORD_W-1:0]      extent_y,
  output logic                    last_tile
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ROOT,
    S_ROWS,
    S_CHECK,
    S_DIVX,
    S_DIVY,
    S_EMIT
  } state_t;

  state_t state;

  logic [CNT_W-1:0]   count_r;
  logic [COORD_W-1:0] width_r;
  logic [COORD_W-1:0] height_r;
  logic [CNT_W-1:0]   cols;
  logic [CNT_W-1:0]   rows;
  logic [ROOT_W-1:0]  s_r;
  logic [SQ_W-1:0]    sq_r;
  logic [SQ_W-1:0]    ssq_r;

  logic               div_go;
  logic [COORD_W-1:0] div_a;
  logic [CNT_W-1:0]   div_b;
  logic               div_done;
  div_res_t           div_res;

  logic [COORD_W-1:0] qx;
  logic [CNT_W-1:0]   rx;
  logic [COORD_W-1:0] qy;
  logic [CNT_W-1:0]   ry;

  logic [CNT_W-1:0]   c_cnt;
  logic [CNT_W-1:0]   r_cnt;
  logic [CNT_W-1:0]   n_cnt;
  logic [COORD_W-1:0] x0;
  logic [CNT_W-1:0]   xrem;
  logic [COORD_W-1:0] y0;
  logic [CNT_W-1:0]   yrem;

  logic [CNT_W-1:0]   count_sat;
  logic [CNT_W:0]     xsum;
  logic [CNT_W:0]     ysum;
  logic               xcarry;
  logic               ycarry;
  logic [COORD_W-1:0] dx;
  logic [COORD_W-1:0] dy;
  logic [CNT_W-1:0]   xrem_next;
  logic [CNT_W-1:0]   yrem_next;
  logic               last_col;
  logic               last_row;
  logic [CNT_W-1:0]   cols_pow2;

  // shared divider
  itg_div u_div (
    .clk      (clk),
    .rst      (rst),
    .go       (div_go),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .res      (div_res)
  );

  // tile count saturation
  assign count_sat = (32'(tile_count) > MAX_TILES) ? CNT_W'(MAX_TILES) : tile_count;

  assign cols_pow2 = pow2_ceil(s_r);

  // incremental edge stepping: edge(i+1) = edge(i) + q + carry of the remainder
  always_comb begin
    xsum      = {1'b0, xrem} + {1'b0, rx};
    xcarry    = (xsum >= {1'b0, cols});
    xrem_next = xcarry ? CNT_W'(xsum - {1'b0, cols}) : xsum[CNT_W-1:0];
    dx        = qx + COORD_W'(xcarry);
    ysum      = {1'b0, yrem} + {1'b0, ry};
    ycarry    = (ysum >= {1'b0, rows});
    yrem_next = ycarry ? CNT_W'(ysum - {1'b0, rows}) : ysum[CNT_W-1:0];
    dy        = qy + COORD_W'(ycarry);
    last_col  = (c_cnt == cols - CNT_W'(1));
    last_row  = (r_cnt == rows - CNT_W'(1));
  end

  assign busy = (state != S_IDLE);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      tile_valid <= 1'b0;
      div_go     <= 1'b0;
    end else begin
      tile_valid <= 1'b0;
      div_go     <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            count_r  <= count_sat;
            width_r  <= frame_width;
            height_r <= frame_height;
            s_r      <= '0;
            sq_r     <= SQ_W'(1);
            ssq_r    <= '0;
            unique case (strategy_t'(strategy))
              STRAT_VERT: begin
                cols  <= count_sat;
                rows  <= CNT_W'(1);
                state <= S_CHECK;
              end
              STRAT_HORZ: begin
                cols  <= CNT_W'(1);
                rows  <= count_sat;
                state <= S_CHECK;
              end
              STRAT_RECT: begin
                state <= S_ROOT;
              end
              STRAT_SINGLE: begin
                cols  <= CNT_W'(1);
                rows  <= CNT_W'(1);
                state <= S_CHECK;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        // integer square root by stepping odd increments
        S_ROOT: begin
          if ({1'b0, count_r} >= sq_r) begin
            s_r   <= s_r + ROOT_W'(1);
            ssq_r <= sq_r;
            sq_r  <= sq_r + SQ_W'({s_r, 1'b0}) + SQ_W'(3);
          end else if (ssq_r == {1'b0, count_r}) begin
            cols  <= CNT_W'(s_r);
            rows  <= CNT_W'(s_r);
            state <= S_CHECK;
          end else begin
            cols   <= cols_pow2;
            div_a  <= COORD_W'(count_r);
            div_b  <= cols_pow2;
            div_go <= 1'b1;
            state  <= S_ROWS;
          end
        end
        S_ROWS: begin
          if (div_done) begin
            rows  <= div_res.quot[CNT_W-1:0];
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if ((cols == '0) || (rows == '0)) begin
            state <= S_IDLE;
          end else begin
            div_a  <= width_r;
            div_b  <= cols;
            div_go <= 1'b1;
            state  <= S_DIVX;
          end
        end
        S_DIVX: begin
          if (div_done) begin
            qx     <= div_res.quot;
            rx     <= div_res.rem;
            div_a  <= height_r;
            div_b  <= rows;
            div_go <= 1'b1;
            state  <= S_DIVY;
          end
        end
        S_DIVY: begin
          if (div_done) begin
            qy    <= div_res.quot;
            ry    <= div_res.rem;
            c_cnt <= '0;
            r_cnt <= '0;
            n_cnt <= '0;
            x0    <= '0;
            xrem  <= '0;
            y0    <= '0;
            yrem  <= '0;
            state <= S_EMIT;
          end
        end
        // one tile per cycle, columns fastest
        S_EMIT: begin
          tile_valid <= 1'b1;
          tile_id    <= n_cnt[ID_W-1:0];
          origin_x   <= x0;
          origin_y   <= y0;
          extent_x   <= dx;
          extent_y   <= dy;
          last_tile  <= last_col && last_row;
          n_cnt      <= n_cnt + CNT_W'(1);
          if (last_col) begin
            c_cnt <= '0;
            x0    <= '0;
            xrem  <= '0;
            if (last_row) begin
              state <= S_IDLE;
            end else begin
              r_cnt <= r_cnt + CNT_W'(1);
              y0    <= y0 + dy;
              yrem  <= yrem_next;
            end
          end else begin
            c_cnt <= c_cnt + CNT_W'(1);
            x0    <= x0 + dx;
            xrem  <= xrem_next;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> test/tb.sv
// ---------------------------------------------------------------------------
// tb: testbench for image_tile_grid_generator_core
// Sends split requests through the start/busy handshake and checks every
// tile strobe against a tile list predicted inside the testbench. A short
// directed set covers zero counts, saturation, extreme image sizes and
// square and non-square rectangles. Random requests follow, in phases with
// and without sender idle cycles.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb;
  import itg_pkg::*;

  localparam int TILE_LIMIT = 64;
  localparam int MAX_SHOWN  = 10;

  // one split request
  typedef struct packed {
    strategy_t          strat;
    logic [CNT_W-1:0]   count;
    logic [COORD_W-1:0] wid;
    logic [COORD_W-1:0] hgt;
  } split_req_t;

  // one tile as it appears on the result ports
  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [COORD_W-1:0] ox;
    logic [COORD_W-1:0] oy;
    logic [COORD_W-1:0] ex;
    logic [COORD_W-1:0] ey;
    logic               last;
  } tile_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  strategy_t          strategy = STRAT_VERT;
  logic [CNT_W-1:0]   tile_count = '0;
  logic [COORD_W-1:0] frame_width = '0;
  logic [COORD_W-1:0] frame_height = '0;
  logic               tile_valid;
  logic [ID_W-1:0]    tile_id;
  logic [COORD_W-1:0] origin_x;
  logic [COORD_W-1:0] origin_y;
  logic [COORD_W-1:0] extent_x;
  logic [COORD_W-1:0] extent_y;
  logic               last_tile;

  split_req_t pending_reqs[$];
  tile_t      expected_tiles[$];
  split_req_t next_req;
  tile_t      want_tile;
  tile_t      got_tile;
  logic       req_taken = 1'b0;
  int         idle_pct = 0;
  int         n_reqs = 0;
  int         n_tiles = 0;
  int         n_errs = 0;
  int         strat_hits[4] = '{0, 0, 0, 0};

  image_tile_grid_generator_core #(
    .MAX_TILES(TILE_LIMIT)
  ) u_dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .strategy    (strategy),
    .tile_count  (tile_count),
    .frame_width (frame_width),
    .frame_height(frame_height),
    .tile_valid  (tile_valid),
    .tile_id     (tile_id),
    .origin_x    (origin_x),
    .origin_y    (origin_y),
    .extent_x    (extent_x),
    .extent_y    (extent_y),
    .last_tile   (last_tile)
  );

  // clock
  always #10 clk = ~clk;

  // edge i of an axis of span pixels split into parts pieces
  function automatic logic [COORD_W-1:0] tile_edge(input int unsigned idx,
                                                   input logic [COORD_W-1:0] span,
                                                   input int unsigned parts);
    longint unsigned prod;
    prod = idx;
    prod = prod * span;
    return COORD_W'(prod / parts);
  endfunction

  // predict the tile grid of one request and queue it in row-major order
  function automatic void predict_tiles(input strategy_t strat,
                                        input logic [CNT_W-1:0] cnt_in,
                                        input logic [COORD_W-1:0] wid,
                                        input logic [COORD_W-1:0] hgt);
    int unsigned cnt;
    int unsigned cols;
    int unsigned rows;
    int unsigned root;
    int unsigned total;
    int unsigned n;
    tile_t t;
    cnt = (cnt_in > TILE_LIMIT) ? TILE_LIMIT : cnt_in;
    case (strat)
      STRAT_VERT: begin
        cols = cnt;
        rows = 1;
      end
      STRAT_HORZ: begin
        cols = 1;
        rows = cnt;
      end
      STRAT_RECT: begin
        root = 0;
        while ((root + 1) * (root + 1) <= cnt) root++;
        if (root * root == cnt) begin
          cols = root;
          rows = root;
        end else begin
          // non-square: columns are the root rounded up to a power of two
          cols = 1;
          while (cols < root) cols = cols << 1;
          rows = cnt / cols;
        end
      end
      default: begin
        cols = 1;
        rows = 1;
      end
    endcase
    if (cols == 0 || rows == 0) return;
    total = cols * rows;
    n = 0;
    for (int unsigned r = 0; r < rows; r++) begin
      for (int unsigned c = 0; c < cols; c++) begin
        t.id   = n[ID_W-1:0];
        t.ox   = tile_edge(c, wid, cols);
        t.oy   = tile_edge(r, hgt, rows);
        t.ex   = tile_edge(c + 1, wid, cols) - t.ox;
        t.ey   = tile_edge(r + 1, hgt, rows) - t.oy;
        t.last = (n + 1 == total);
        expected_tiles.insert(expected_tiles.size(), t);
        n++;
      end
    end
  endfunction

  function automatic void add_req(input strategy_t strat, input int cnt,
                                  input int wid, input int hgt);
    split_req_t q;
    q.strat = strat;
    q.count = CNT_W'(cnt);
    q.wid   = COORD_W'(wid);
    q.hgt   = COORD_W'(hgt);
    pending_reqs.insert(pending_reqs.size(), q);
  endfunction

  // image size along one axis: extremes, tiny sizes or anything
  function automatic int rand_span();
    case ($urandom_range(7))
      0:       return 0;
      1:       return 65535;
      2:       return $urandom_range(8, 1);
      default: return $urandom_range(65535);
    endcase
  endfunction

  // tile count: mostly within the limit, some above it, some zero
  function automatic int rand_count();
    case ($urandom_range(9))
      0:       return $urandom_range(127, 65);
      1:       return 0;
      2:       return $urandom_range(4, 1);
      default: return $urandom_range(64, 1);
    endcase
  endfunction

  // request driver: change inputs on the falling edge
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!start || req_taken) begin
      if (pending_reqs.size() != 0 && $urandom_range(99) >= idle_pct) begin
        next_req = pending_reqs.pop_front();
        strategy     <= next_req.strat;
        tile_count   <= next_req.count;
        frame_width  <= next_req.wid;
        frame_height <= next_req.hgt;
        start        <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: predict on each accepted request, check each tile strobe
  always @(posedge clk) begin
    req_taken <= !rst && start && !busy;
    if (!rst && start && !busy) begin
      predict_tiles(strategy, tile_count, frame_width, frame_height);
      n_reqs++;
      strat_hits[strategy]++;
    end
    if (!rst && tile_valid) begin
      n_tiles++;
      got_tile = '{tile_id, origin_x, origin_y, extent_x, extent_y, last_tile};
      if (expected_tiles.size() == 0) begin
        n_errs++;
        if (n_errs <= MAX_SHOWN)
          $display("%0t: unexpected tile id=%0d x=%0d y=%0d w=%0d h=%0d last=%0b",
                   $realtime, tile_id, origin_x, origin_y, extent_x, extent_y,
                   last_tile);
      end else begin
        want_tile = expected_tiles.pop_front();
        if (got_tile !== want_tile) begin
          n_errs++;
          if (n_errs <= MAX_SHOWN) begin
            $display("%0t: tile mismatch", $realtime);
            $display("  expected id=%0d x=%0d y=%0d w=%0d h=%0d last=%0b",
                     want_tile.id, want_tile.ox, want_tile.oy, want_tile.ex,
                     want_tile.ey, want_tile.last);
            $display("  actual   id=%0d x=%0d y=%0d w=%0d h=%0d last=%0b",
                     got_tile.id, got_tile.ox, got_tile.oy, got_tile.ex,
                     got_tile.ey, got_tile.last);
          end
        end
      end
    end
  end

  // run limit
  initial begin
    #20ms;
    $display("image_tile_grid_generator_core test failed");
    $finish;
  end

  // stimulus and end of run
  initial begin
    int phase_idle[4];
    phase_idle = '{0, 49, 0, 26};
    repeat (9) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // directed requests
    add_req(STRAT_VERT, 0, 640, 480);
    add_req(STRAT_HORZ, 0, 640, 480);
    add_req(STRAT_RECT, 0, 640, 480);
    add_req(STRAT_SINGLE, 0, 640, 480);
    add_req(STRAT_SINGLE, 127, 65535, 65535);
    add_req(STRAT_SINGLE, 0, 0, 0);
    add_req(STRAT_VERT, 1, 65535, 65535);
    add_req(STRAT_VERT, 64, 65535, 1);
    add_req(STRAT_VERT, 65, 123, 45);
    add_req(STRAT_VERT, 7, 5, 3);
    add_req(STRAT_HORZ, 127, 1000, 65535);
    add_req(STRAT_HORZ, 64, 0, 0);
    add_req(STRAT_HORZ, 3, 65535, 65534);
    add_req(STRAT_RECT, 1, 1920, 1080);
    add_req(STRAT_RECT, 2, 1920, 1080);
    add_req(STRAT_RECT, 3, 1920, 1080);
    add_req(STRAT_RECT, 5, 1, 1);
    add_req(STRAT_RECT, 8, 0, 777);
    add_req(STRAT_RECT, 9, 1000, 1000);
    add_req(STRAT_RECT, 10, 333, 65535);
    add_req(STRAT_RECT, 16, 65535, 0);
    add_req(STRAT_RECT, 63, 4095, 2047);
    add_req(STRAT_RECT, 64, 65535, 65535);
    add_req(STRAT_RECT, 100, 12345, 54321);

    // random requests in phases of different sender pacing
    for (int ph = 0; ph < 5; ph++) begin
      if (ph > 0) begin
        idle_pct = phase_idle[ph - 1];
        repeat (36) add_req(strategy_t'($urandom_range(3)), rand_count(),
                            rand_span(), rand_span());
      end
      while (pending_reqs.size() != 0 || start || req_taken || busy ||
             expected_tiles.size() != 0)
        @(posedge clk);
    end

    // drain: let any late tile show up
    repeat (100) @(posedge clk);
    n_errs += expected_tiles.size();

    $display("%0d requests sent (vert %0d, horz %0d, rect %0d, single %0d)",
             n_reqs, strat_hits[STRAT_VERT], strat_hits[STRAT_HORZ],
             strat_hits[STRAT_RECT], strat_hits[STRAT_SINGLE]);
    $display("%0d tiles checked, %0d errors", n_tiles, n_errs);
    if (n_errs == 0) begin
      $display("image_tile_grid_generator_core test passed");
    end else begin
      $display("image_tile_grid_generator_core test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
